// ===== rtl/core/trs_pkg.sv =====
// Package for the timed relay button sequencer.
// Holds the phase codes, the register indexes, the reset values and the shared structs.
// No dependencies.
package trs_pkg;

  typedef logic [2:0] phase_t;

  localparam phase_t PH_POWER_WAIT  = 3'd0;
  localparam phase_t PH_PERIOD_WAIT = 3'd1;
  localparam phase_t PH_PANEL_HELD  = 3'd2;
  localparam phase_t PH_GAP         = 3'd3;
  localparam phase_t PH_FILTER_HELD = 3'd4;
  localparam phase_t PH_RUNNING     = 3'd5;
  localparam phase_t PH_FINAL_HELD  = 3'd6;

  localparam int unsigned CFG_INDEX_W = 3;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_POWER_ON_DELAY = 3'd0;
  localparam cfg_index_t REG_PRESS_TIME     = 3'd1;
  localparam cfg_index_t REG_PRESS_GAP      = 3'd2;
  localparam cfg_index_t REG_RUN_TIME       = 3'd3;
  localparam cfg_index_t REG_CYCLE_PERIOD   = 3'd4;

  localparam logic [31:0] POWER_ON_DELAY_RST = 32'd5000;
  localparam logic [31:0] PRESS_TIME_RST     = 32'd500;
  localparam logic [31:0] PRESS_GAP_RST      = 32'd3000;
  localparam logic [31:0] RUN_TIME_RST       = 32'd7200000;
  localparam logic [31:0] CYCLE_PERIOD_RST   = 32'd86184000;

  typedef struct packed {
    logic [31:0] power_on_delay_ms;
    logic [31:0] press_time_ms;
    logic [31:0] press_gap_ms;
    logic [31:0] run_time_ms;
    logic [31:0] cycle_period_ms;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] last_change_ms;
    logic [31:0] cycle_start_ms;
    logic        panel_level;
    logic        filter_level;
    logic        led_level;
  } seq_state_t;

endpackage

// ===== rtl/core/trs_step.sv =====
// Next-state logic of the sequencer for one timestamp.
// One wrapping subtract and one unsigned compare select the phase change.
// Depends on trs_pkg.
module trs_step (
  input  trs_pkg::seq_state_t cur,
  input  trs_pkg::cfg_t       cfg,
  input  logic [31:0]         now_ms,
  output trs_pkg::seq_state_t nxt
);
  import trs_pkg::*;

  logic [31:0] since;
  logic [31:0] span;
  logic [31:0] elapsed;
  logic        done;

  always_comb begin
    since = cur.last_change_ms;
    span  = cfg.press_time_ms;
    case (cur.phase)
      PH_POWER_WAIT: span = cfg.power_on_delay_ms;
      PH_PERIOD_WAIT: begin
        since = cur.cycle_start_ms;
        span  = cfg.cycle_period_ms;
      end
      PH_GAP:     span = cfg.press_gap_ms;
      PH_RUNNING: span = cfg.run_time_ms;
      default:    span = cfg.press_time_ms;
    endcase
  end

  assign elapsed = now_ms - since;
  assign done    = (elapsed >= span);

  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      PH_POWER_WAIT, PH_PERIOD_WAIT: begin
        if (done) begin
          nxt.led_level      = 1'b1;
          nxt.panel_level    = 1'b1;
          nxt.cycle_start_ms = now_ms;
          nxt.last_change_ms = now_ms;
          nxt.phase          = PH_PANEL_HELD;
        end
      end
      PH_PANEL_HELD: begin
        if (done) begin
          nxt.panel_level    = 1'b0;
          nxt.last_change_ms = now_ms;
          nxt.phase          = PH_GAP;
        end
      end
      PH_GAP: begin
        if (done) begin
          nxt.filter_level   = 1'b1;
          nxt.last_change_ms = now_ms;
          nxt.phase          = PH_FILTER_HELD;
        end
      end
      PH_FILTER_HELD: begin
        if (done) begin
          nxt.filter_level   = 1'b0;
          nxt.last_change_ms = now_ms;
          nxt.phase          = PH_RUNNING;
        end
      end
      PH_RUNNING: begin
        if (done) begin
          nxt.panel_level    = 1'b1;
          nxt.last_change_ms = now_ms;
          nxt.phase          = PH_FINAL_HELD;
        end
      end
      PH_FINAL_HELD: begin
        if (done) begin
          nxt.panel_level    = 1'b0;
          nxt.led_level      = 1'b0;
          nxt.last_change_ms = now_ms;
          nxt.phase          = PH_PERIOD_WAIT;
        end
      end
      default: begin
        nxt.last_change_ms = now_ms;
        nxt.phase          = PH_POWER_WAIT;
      end
    endcase
  end

endmodule

// ===== rtl/core/timed_relay_button_sequencer.sv =====
// Top level of the timed relay button sequencer.
// Input register, next-state logic in trs_step, result register and configuration registers.
// Depends on trs_pkg and trs_step.
//
// Each accepted now_ms timestamp advances the seven-phase relay sequencer once and yields
// one transfer on the output channel with the relay, LED and phase levels after that update.
// A timestamp goes from input transfer to output transfer through the input register, then
// the result register; one timestamp is accepted every cycle while the output is not stalled;
// the rate is set by the single state update per cycle, a 32-bit subtract and compare.
// Elapsed times wrap modulo 2^32; cfg_ready is always high. The user writes registers through the
// cfg port only while the block is idle, which the block does not enforce; writes to indexes beyond 4 are ignored.
module timed_relay_button_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         now_ms,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                panel_relay,
  output logic                filter_relay,
  output logic                busy_led,
  output logic [2:0]          phase,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  trs_pkg::cfg_index_t cfg_index,
  input  logic [31:0]         cfg_data
);
  import trs_pkg::*;

  cfg_t        cfg;
  seq_state_t  state;
  seq_state_t  state_next;
  logic        hold_valid;
  logic [31:0] hold_now;
  logic        advance;

  assign cfg_ready = 1'b1;
  assign advance   = hold_valid && (!out_valid || !out_stall);
  assign in_stall  = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_on_delay_ms <= POWER_ON_DELAY_RST;
      cfg.press_time_ms     <= PRESS_TIME_RST;
      cfg.press_gap_ms      <= PRESS_GAP_RST;
      cfg.run_time_ms       <= RUN_TIME_RST;
      cfg.cycle_period_ms   <= CYCLE_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POWER_ON_DELAY: cfg.power_on_delay_ms <= cfg_data;
        REG_PRESS_TIME:     cfg.press_time_ms     <= cfg_data;
        REG_PRESS_GAP:      cfg.press_gap_ms      <= cfg_data;
        REG_RUN_TIME:       cfg.run_time_ms       <= cfg_data;
        REG_CYCLE_PERIOD:   cfg.cycle_period_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_now <= now_ms;
    end
  end

  trs_step u_step (
    .cur    (state),
    .cfg    (cfg),
    .now_ms (hold_now),
    .nxt    (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign panel_relay  = state.panel_level;
  assign filter_relay = state.filter_level;
  assign busy_led     = state.led_level;
  assign phase        = state.phase;

endmodule

// ===== rtl/core/trs_checker.sv =====
// Port-level checks for the timed relay button sequencer.
// Bound to the top level; depends on trs_pkg and timed_relay_button_sequencer.
module trs_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       panel_relay,
  input logic       filter_relay,
  input logic       busy_led,
  input logic [2:0] phase
);
  import trs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(phase) && $stable(panel_relay))
    else $error("Stalled output transfer changed.");

  a_panel_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> panel_relay == (phase == PH_PANEL_HELD || phase == PH_FINAL_HELD))
    else $error("Panel relay level disagrees with the phase.");

  a_filter_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> filter_relay == (phase == PH_FILTER_HELD))
    else $error("Filter relay level disagrees with the phase.");

  a_led_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy_led == (phase != PH_POWER_WAIT && phase != PH_PERIOD_WAIT))
    else $error("LED level disagrees with the phase.");

endmodule

bind timed_relay_button_sequencer trs_checker u_trs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .panel_relay  (panel_relay),
  .filter_relay (filter_relay),
  .busy_led     (busy_led),
  .phase        (phase)
);

// ===== dv/timed_relay_button_sequencer_test.sv =====
`timescale 1ns / 1ps
// Testbench for timed_relay_button_sequencer: a directed table of timestamps, then random timing
// settings and timestamp streams, each transfer checked against the table or a sequencer model kept here.
// Depends on trs_pkg and the sequencer RTL.
module timed_relay_button_sequencer_test;
  import trs_pkg::*;

  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int CALM_PHASE = 6;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam cfg_index_t REG_INDEX_MAX = '1;

  typedef enum {SET_ZERO, SET_FULL, SET_SHORT, SET_MIXED} timing_mix_t;

  typedef struct packed {
    logic   panel;
    logic   filter;
    logic   led;
    phase_t phase;
  } levels_t;

  typedef struct {
    logic [31:0] stamp;
    bit          typed;
    levels_t     want;
  } stamp_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        panel_relay;
  logic        filter_relay;
  logic        busy_led;
  logic [2:0]  phase;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = REG_POWER_ON_DELAY;
  logic [31:0] cfg_data = '0;

  cfg_t        timing;
  phase_t      seq_phase;
  logic [31:0] mark_ms;
  logic [31:0] start_ms;
  logic        panel_on;
  logic        filter_on;
  logic        led_on;
  levels_t     levels_due[$];
  int          sent_count = 0;
  int          mismatches = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  // Under the reset timing: power-on wait, one full cycle, the period wait, then time wrap.
  stamp_row_t plan [19] = '{
    '{32'd0,          1'b1, '{1'b0, 1'b0, 1'b0, PH_POWER_WAIT}},
    '{32'd4999,       1'b1, '{1'b0, 1'b0, 1'b0, PH_POWER_WAIT}},
    '{32'd5000,       1'b1, '{1'b1, 1'b0, 1'b1, PH_PANEL_HELD}},
    '{32'd5499,       1'b1, '{1'b1, 1'b0, 1'b1, PH_PANEL_HELD}},
    '{32'd5500,       1'b1, '{1'b0, 1'b0, 1'b1, PH_GAP}},
    '{32'd8499,       1'b0, '0},
    '{32'd8500,       1'b1, '{1'b0, 1'b1, 1'b1, PH_FILTER_HELD}},
    '{32'd9000,       1'b1, '{1'b0, 1'b0, 1'b1, PH_RUNNING}},
    '{32'd7209000,    1'b1, '{1'b1, 1'b0, 1'b1, PH_FINAL_HELD}},
    '{32'd7209500,    1'b1, '{1'b0, 1'b0, 1'b0, PH_PERIOD_WAIT}},
    '{32'd86188999,   1'b0, '0},
    '{32'd86189000,   1'b1, '{1'b1, 1'b0, 1'b1, PH_PANEL_HELD}},
    '{32'hFFFF_FFFF,  1'b1, '{1'b0, 1'b0, 1'b1, PH_GAP}},
    '{32'd0,          1'b0, '0},
    '{32'd2999,       1'b1, '{1'b0, 1'b1, 1'b1, PH_FILTER_HELD}},
    '{32'hFFFF_0000,  1'b0, '0},
    '{32'h7FFF_FFFF,  1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0},
    '{32'h5555_5555,  1'b0, '0}
  };

  timed_relay_button_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .panel_relay  (panel_relay),
    .filter_relay (filter_relay),
    .busy_led     (busy_led),
    .phase        (phase),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic bit span_elapsed(input logic [31:0] t, input logic [31:0] since,
                                      input logic [31:0] span);
    logic [31:0] diff;
    diff = t - since;
    return diff >= span;
  endfunction

  function automatic void start_cycle(input logic [31:0] t);
    led_on = 1'b1;
    panel_on = 1'b1;
    start_ms = t;
    mark_ms = t;
    seq_phase = PH_PANEL_HELD;
  endfunction

  function automatic levels_t advance_sequencer(input logic [31:0] t);
    case (seq_phase)
      PH_POWER_WAIT: begin
        if (span_elapsed(t, mark_ms, timing.power_on_delay_ms)) start_cycle(t);
      end
      PH_PERIOD_WAIT: begin
        if (span_elapsed(t, start_ms, timing.cycle_period_ms)) start_cycle(t);
      end
      PH_PANEL_HELD: begin
        if (span_elapsed(t, mark_ms, timing.press_time_ms)) begin
          panel_on = 1'b0;
          seq_phase = PH_GAP;
          mark_ms = t;
        end
      end
      PH_GAP: begin
        if (span_elapsed(t, mark_ms, timing.press_gap_ms)) begin
          filter_on = 1'b1;
          seq_phase = PH_FILTER_HELD;
          mark_ms = t;
        end
      end
      PH_FILTER_HELD: begin
        if (span_elapsed(t, mark_ms, timing.press_time_ms)) begin
          filter_on = 1'b0;
          seq_phase = PH_RUNNING;
          mark_ms = t;
        end
      end
      PH_RUNNING: begin
        if (span_elapsed(t, mark_ms, timing.run_time_ms)) begin
          panel_on = 1'b1;
          seq_phase = PH_FINAL_HELD;
          mark_ms = t;
        end
      end
      PH_FINAL_HELD: begin
        if (span_elapsed(t, mark_ms, timing.press_time_ms)) begin
          panel_on = 1'b0;
          led_on = 1'b0;
          seq_phase = PH_PERIOD_WAIT;
          mark_ms = t;
        end
      end
      default: begin
        seq_phase = PH_POWER_WAIT;
        mark_ms = t;
      end
    endcase
    return '{panel_on, filter_on, led_on, seq_phase};
  endfunction

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_POWER_ON_DELAY: timing.power_on_delay_ms = data;
      REG_PRESS_TIME:     timing.press_time_ms = data;
      REG_PRESS_GAP:      timing.press_gap_ms = data;
      REG_RUN_TIME:       timing.run_time_ms = data;
      REG_CYCLE_PERIOD:   timing.cycle_period_ms = data;
      default: ;
    endcase
  endtask

  task automatic send_stamp(input logic [31:0] t, input bit typed, input levels_t want);
    levels_t model;
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    now_ms <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model = advance_sequencer(t);
    levels_due.push_back(typed ? want : model);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    levels_t got;
    levels_t want;
    int      hold_left;
    bit      held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = '{panel_relay, filter_relay, busy_led, phase};
        if (levels_due.size() == 0) begin
          $error("Unexpected transfer: panel_relay %0b filter_relay %0b busy_led %0b phase %0d",
                 got.panel, got.filter, got.led, got.phase);
          mismatches++;
        end else begin
          want = levels_due.pop_front();
          if (got.panel !== want.panel) begin
            $error("panel_relay: expected %0b, actual %0b", want.panel, got.panel);
            mismatches++;
          end
          if (got.filter !== want.filter) begin
            $error("filter_relay: expected %0b, actual %0b", want.filter, got.filter);
            mismatches++;
          end
          if (got.led !== want.led) begin
            $error("busy_led: expected %0b, actual %0b", want.led, got.led);
            mismatches++;
          end
          if (got.phase !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, got.phase);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && sent_count >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 22);
      end
    end
  end

  initial begin
    logic [31:0] cur;
    logic [31:0] setting;
    timing_mix_t mix;
    int          step_max;
    int          pick;
    timing = '{POWER_ON_DELAY_RST, PRESS_TIME_RST, PRESS_GAP_RST, RUN_TIME_RST,
               CYCLE_PERIOD_RST};
    seq_phase = PH_POWER_WAIT;
    mark_ms = '0;
    start_ms = '0;
    panel_on = 1'b0;
    filter_on = 1'b0;
    led_on = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) send_stamp(plan[i].stamp, plan[i].typed, plan[i].want);
    cur = $urandom;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      calm = (p == CALM_PHASE);
      mix = timing_mix_t'(p % 4);
      for (int r = REG_POWER_ON_DELAY; r <= REG_CYCLE_PERIOD; r++) begin
        case (mix)
          SET_ZERO: setting = '0;
          SET_FULL: setting = '1;
          SET_SHORT: begin
            setting = (r == REG_CYCLE_PERIOD) ? $urandom_range(40, 200) : $urandom_range(1, 30);
          end
          default: begin
            pick = $urandom_range(99);
            if (pick < 30) setting = '0;
            else if (pick < 70) setting = $urandom_range(1, 400);
            else setting = $urandom;
          end
        endcase
        write_reg(cfg_index_t'(r), setting);
      end
      write_reg(cfg_index_t'($urandom_range(REG_CYCLE_PERIOD + 1, REG_INDEX_MAX)), $urandom);
      cfg_valid <= 1'b0;
      case (mix)
        SET_SHORT: step_max = 12;
        SET_MIXED: step_max = 200;
        default:   step_max = 3;
      endcase
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 8) cur = $urandom;
        else if (pick < 12) cur = cur - $urandom_range(1, 20);
        else cur = cur + $urandom_range(0, step_max);
        send_stamp(cur, 1'b0, '0);
      end
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
